FILE: rtl/core/thmrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tagged min-heap request scheduler.
package thmrs_pkg;

	localparam int HEAP_DEPTH = 64;
	localparam int NUM_LEVELS = $clog2(HEAP_DEPTH + 1);
	localparam int CNT_W      = NUM_LEVELS;
	localparam int LIDX_W     = NUM_LEVELS - 1;
	localparam int LVL_W      = $clog2(NUM_LEVELS);
	localparam int TAG_W      = 31;
	localparam int ID_W       = 16;
	localparam int COST_W     = 16;

	localparam logic [COST_W-1:0] COST_RESET = 16'd100;

	typedef enum logic {
		OP_ENQUEUE  = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_EMPTY    = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_OVERFLOW = 2'd3
	} status_t;

	typedef struct packed {
		op_t             operation;
		logic [ID_W-1:0] request_id;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  dispatched_id;
		logic [TAG_W-1:0] dispatched_tag;
		logic [CNT_W-1:0] queued_count;
	} rsp_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [ID_W-1:0]  id;
	} entry_t;

	// Walk token handed from one level cell to the next.
	typedef struct packed {
		logic              valid;
		op_t               op;
		logic              shift;
		logic [LVL_W-1:0]  last_lvl;
		logic [CNT_W-1:0]  path;
		logic [CNT_W-1:0]  size;
		logic [LIDX_W-1:0] p;
		entry_t            item;
	} tok_t;

	// Write into the parent level, local slot p.
	typedef struct packed {
		logic              valid;
		logic [LIDX_W-1:0] p;
		entry_t            item;
	} wb_t;

endpackage

FILE: rtl/core/thmrs_cell.sv
`timescale 1ns / 1ps
// One heap level: slot storage in two child banks plus one compare step of the walk.
module thmrs_cell #(
	parameter int LEVEL = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  thmrs_pkg::tok_t               tok_in,
	output thmrs_pkg::tok_t               tok_out,
	input  thmrs_pkg::wb_t                wb_in,
	output thmrs_pkg::wb_t                wb_out,
	input  logic [thmrs_pkg::LIDX_W-1:0]  last_k,
	output thmrs_pkg::entry_t             last_entry,
	output logic                          done
);
	import thmrs_pkg::*;

	localparam int AW       = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int BANK_D   = 1 << AW;
	localparam int PATH_BIT = NUM_LEVELS - 1 - LEVEL;
	localparam logic [CNT_W-1:0] BASE = CNT_W'((1 << LEVEL) - 1);

	// bank0 holds left children, bank1 right children, both indexed by parent slot
	entry_t bank0_q [BANK_D];
	entry_t bank1_q [BANK_D];
	entry_t rd0_q, rd1_q;
	logic   last_b_q;

	tok_t   cur_s1;
	tok_t   tok_q, tok_d;
	wb_t    wb_q, wb_d;
	logic   done_q, done_d;

	logic [AW-1:0] rd_addr;
	logic          wr_en, wr_bank;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          lw_en, lw_bank;

	logic              b_enq, take, is_last;
	entry_t            x_enq, cand, child;
	logic [LIDX_W-1:0] k_l;
	logic [CNT_W-1:0]  g_l, g_r, gc;
	logic              pick_l, pick_r, leaf;

	assign rd_addr = tok_in.valid ? tok_in.p[AW-1:0] : last_k[AW:1];

	always_comb begin
		b_enq   = cur_s1.path[PATH_BIT];
		x_enq   = b_enq ? rd1_q : rd0_q;
		take    = cur_s1.shift || (cur_s1.item.tag < x_enq.tag);
		is_last = (cur_s1.last_lvl == LVL_W'(LEVEL));

		k_l    = {cur_s1.p[LIDX_W-2:0], 1'b0};
		g_l    = BASE + CNT_W'(k_l);
		g_r    = g_l + CNT_W'(1);
		pick_l = (g_l < cur_s1.size) && (rd0_q.tag < cur_s1.item.tag);
		cand   = pick_l ? rd0_q : cur_s1.item;
		pick_r = (g_r < cur_s1.size) && (rd1_q.tag < cand.tag);
		child  = pick_r ? rd1_q : rd0_q;
		gc     = pick_r ? g_r : g_l;
		// child has no children of its own
		leaf   = {gc, 1'b1} >= {1'b0, cur_s1.size};

		tok_d       = cur_s1;
		tok_d.valid = 1'b0;
		wb_d        = '0;
		done_d      = 1'b0;
		lw_en       = 1'b0;
		lw_bank     = 1'b0;

		if (cur_s1.valid) begin
			if (cur_s1.op == OP_ENQUEUE) begin
				lw_bank = b_enq;
				if (is_last) begin
					lw_en  = 1'b1;
					done_d = 1'b1;
				end else begin
					lw_en       = take;
					tok_d.valid = 1'b1;
					tok_d.p     = {cur_s1.p[LIDX_W-2:0], b_enq};
					tok_d.shift = take;
					tok_d.item  = take ? x_enq : cur_s1.item;
				end
			end else begin
				wb_d.valid = 1'b1;
				wb_d.p     = cur_s1.p;
				if (!pick_l && !pick_r) begin
					wb_d.item = cur_s1.item;
					done_d    = 1'b1;
				end else begin
					wb_d.item = child;
					lw_bank   = pick_r;
					if (leaf) begin
						lw_en  = 1'b1;
						done_d = 1'b1;
					end else begin
						tok_d.valid = 1'b1;
						tok_d.p     = {cur_s1.p[LIDX_W-2:0], pick_r};
					end
				end
			end
		end
	end

	// write-back from the level below and local writes never fall in the same cycle
	always_comb begin
		if (wb_in.valid) begin
			wr_en   = 1'b1;
			wr_bank = wb_in.p[0];
			wr_addr = wb_in.p[AW:1];
			wr_data = wb_in.item;
		end else begin
			wr_en   = lw_en;
			wr_bank = lw_bank;
			wr_addr = cur_s1.p[AW-1:0];
			wr_data = cur_s1.item;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_bank) begin
			bank0_q[wr_addr] <= wr_data;
		end
		if (wr_en && wr_bank) begin
			bank1_q[wr_addr] <= wr_data;
		end
		rd0_q    <= bank0_q[rd_addr];
		rd1_q    <= bank1_q[rd_addr];
		last_b_q <= last_k[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_s1 <= '0;
			tok_q  <= '0;
			wb_q   <= '0;
			done_q <= 1'b0;
		end else begin
			cur_s1 <= tok_in;
			tok_q  <= tok_d;
			wb_q   <= wb_d;
			done_q <= done_d;
		end
	end

	assign tok_out    = tok_q;
	assign wb_out     = wb_q;
	assign done       = done_q;
	assign last_entry = last_b_q ? rd1_q : rd0_q;

endmodule

FILE: rtl/core/tagged_min_heap_request_scheduler.sv
`timescale 1ns / 1ps
// Top level: start-time fair queueing scheduler over a level-per-cell min-heap.
//
// Each request transfer is either an enqueue (the request gets start tag =
// virtual time, raised first to the latest finish tag when the queue is not
// empty, and finish tag = start + request_cost) or a dispatch (pop the
// smallest start tag). Every request yields exactly one response transfer.
// The heap holds 64 entries; the root lives here and every further level is a
// cell of a chain, each cell owning that level's slots in two banks (left and
// right children) with a registered read. A walk token moves down the chain;
// each cell first reads, then compares and writes, and on a dispatch hands
// moved entries back up to its parent level. One item is in work at a time;
// refusals, enqueue into an empty queue and dispatch of the only entry skip
// the walk. The next request can be taken in the cycle after the response is
// loaded, even while that response is still stalled. request_cost is written
// through cfg_we/cfg_wdata and must only change while the block is idle; it
// resets to 100. There is no clearing pass: heap slots need no reset.
module tagged_min_heap_request_scheduler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  thmrs_pkg::req_t               req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output thmrs_pkg::rsp_t               rsp_data,
	input  logic                          cfg_we,
	input  logic [thmrs_pkg::COST_W-1:0]  cfg_wdata
);
	import thmrs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LAST,
		ST_WAIT,
		ST_FINISH
	} state_t;

	function automatic logic [LVL_W-1:0] msb_pos(input logic [CNT_W-1:0] n);
		logic [LVL_W-1:0] pos;
		pos = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (n[i]) begin
				pos = LVL_W'(i);
			end
		end
		return pos;
	endfunction

	state_t            state_q;
	logic [CNT_W-1:0]  size_q;
	logic [TAG_W-1:0]  vclock_q, latest_q;
	logic [COST_W-1:0] cost_q;
	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	status_t           res_status_q;
	logic [ID_W-1:0]   res_id_q;
	logic [TAG_W-1:0]  res_tag_q;
	logic [LVL_W-1:0]  lr_lvl_q;
	tok_t              tok_q;
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;
	entry_t            root_q;

	// chain wiring: tok_w[L] and wb_w[L+1] feed cell L
	tok_t              tok_w  [1:NUM_LEVELS];
	wb_t               wb_w   [1:NUM_LEVELS];
	entry_t            last_w [1:NUM_LEVELS-1];
	logic [NUM_LEVELS-1:1] done_v;

	logic [CNT_W-1:0]  n_enq, path_enq, k_full;
	logic [LVL_W-1:0]  d_enq, d_last;
	logic [LIDX_W-1:0] last_k;
	logic [TAG_W-1:0]  clk_v;
	logic [TAG_W:0]    fin;
	logic              ovf, full, take_root, enq_go;
	entry_t            new_item, last_entry;
	logic              root_we;
	entry_t            root_wd;

	always_comb begin
		n_enq    = size_q + CNT_W'(1);
		d_enq    = msb_pos(n_enq);
		path_enq = n_enq << (LVL_W'(NUM_LEVELS - 1) - d_enq);

		// latest_q never falls below vclock_q, so no compare is needed
		clk_v = (size_q != '0) ? latest_q : vclock_q;
		fin   = {1'b0, clk_v} + {{(TAG_W + 1 - COST_W){1'b0}}, cost_q};
		ovf   = fin[TAG_W];
		full  = (size_q == CNT_W'(HEAP_DEPTH));

		new_item.tag = clk_v;
		new_item.id  = id_q;
		take_root    = (new_item.tag < root_q.tag);
		enq_go       = (state_q == ST_START) && (op_q == OP_ENQUEUE) && !full && !ovf;

		// slot of the last entry is size_q - 1, i.e. heap number size_q (1-based)
		d_last = msb_pos(size_q);
		k_full = size_q & ~(CNT_W'(1) << d_last);
		last_k = k_full[LIDX_W-1:0];

		last_entry = last_w[1];
		for (int i = 1; i < NUM_LEVELS; i++) begin
			if (lr_lvl_q == LVL_W'(i)) begin
				last_entry = last_w[i];
			end
		end

		root_we = 1'b0;
		root_wd = new_item;
		if (wb_w[1].valid) begin
			root_we = 1'b1;
			root_wd = wb_w[1].item;
		end else if (enq_go && ((size_q == '0) || take_root)) begin
			root_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (root_we) begin
			root_q <= root_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			size_q       <= '0;
			vclock_q     <= '0;
			latest_q     <= '0;
			cost_q       <= COST_RESET;
			op_q         <= OP_ENQUEUE;
			id_q         <= '0;
			res_status_q <= STATUS_OK;
			res_id_q     <= '0;
			res_tag_q    <= '0;
			lr_lvl_q     <= '0;
			tok_q        <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
		end else begin
			// token launched for one cycle: enqueue walk from START, dispatch from LAST
			tok_q.valid <= (state_q == ST_LAST) || (enq_go && (size_q != '0));
			if (cfg_we) begin
				cost_q <= cfg_wdata;
			end
			if ((state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q    <= req_data.operation;
						id_q    <= req_data.request_id;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					res_id_q  <= '0;
					res_tag_q <= '0;
					if (op_q == OP_ENQUEUE) begin
						priority if (full) begin
							res_status_q <= STATUS_FULL;
							state_q      <= ST_FINISH;
						end else if (ovf) begin
							res_status_q <= STATUS_OVERFLOW;
							state_q      <= ST_FINISH;
						end else begin
							vclock_q     <= clk_v;
							latest_q     <= fin[TAG_W-1:0];
							size_q       <= n_enq;
							res_status_q <= STATUS_OK;
							res_tag_q    <= clk_v;
							if (size_q == '0) begin
								state_q <= ST_FINISH;
							end else begin
								tok_q.op       <= OP_ENQUEUE;
								tok_q.shift    <= take_root;
								tok_q.last_lvl <= d_enq;
								tok_q.path     <= path_enq;
								tok_q.size     <= n_enq;
								tok_q.p        <= '0;
								tok_q.item     <= take_root ? root_q : new_item;
								state_q        <= ST_WAIT;
							end
						end
					end else begin
						if (size_q == '0) begin
							res_status_q <= STATUS_EMPTY;
							state_q      <= ST_FINISH;
						end else begin
							res_status_q <= STATUS_OK;
							res_id_q     <= root_q.id;
							res_tag_q    <= root_q.tag;
							size_q       <= size_q - CNT_W'(1);
							lr_lvl_q     <= d_last;
							// cells read the last slot at this edge
							state_q      <= (size_q == CNT_W'(1)) ? ST_FINISH : ST_LAST;
						end
					end
				end
				ST_LAST: begin
					tok_q.op       <= OP_DISPATCH;
					tok_q.shift    <= 1'b0;
					tok_q.last_lvl <= '0;
					tok_q.path     <= '0;
					tok_q.size     <= size_q;
					tok_q.p        <= '0;
					tok_q.item     <= last_entry;
					state_q        <= ST_WAIT;
				end
				ST_WAIT: begin
					if (|done_v) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_data_q.status          <= res_status_q;
						rsp_data_q.dispatched_id   <= res_id_q;
						rsp_data_q.dispatched_tag  <= res_tag_q;
						rsp_data_q.queued_count    <= size_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	// level chain
	assign tok_w[1]          = tok_q;
	assign wb_w[NUM_LEVELS]  = '0;

	for (genvar lv = 1; lv < NUM_LEVELS; lv++) begin : g_cell
		thmrs_cell #(
			.LEVEL(lv)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok_w[lv]),
			.tok_out    (tok_w[lv+1]),
			.wb_in      (wb_w[lv+1]),
			.wb_out     (wb_w[lv]),
			.last_k     (last_k),
			.last_entry (last_w[lv]),
			.done       (done_v[lv])
		);
	end

`ifndef NO_ASSERTIONS
	// the deepest level always finishes the walk itself
	a_no_token_past_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		!tok_w[NUM_LEVELS].valid)
		else $error("walk token left the deepest heap level");

	// a single walk can finish in one cell only
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done_v))
		else $error("more than one level cell reported done");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= CNT_W'(HEAP_DEPTH))
		else $error("heap size beyond depth");

	a_finish_not_behind: assert property (@(posedge clk) disable iff (!arst_n)
		latest_q >= vclock_q)
		else $error("latest finish tag below virtual time");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("response raised outside finish state");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tagged min-heap request scheduler.
module testbench;
	import thmrs_pkg::*;

	// Receiver stall styles.
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_BEAT  = 3;

	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int SETTLE      = 24;    // exceeds the worst item latency
	localparam int IDLE_LIMIT  = 3000;  // cycles with no transfer before giving up
	localparam logic [TAG_W-1:0] TAG_TOP   = '1;
	localparam logic [TAG_W:0]   TAG_LIMIT = {1'b0, TAG_TOP};

	// One directed row: either a cost write or a request, optionally with a
	// hand-written expected response.
	typedef struct packed {
		logic              is_cost;
		logic [COST_W-1:0] cost;
		req_t              req;
		logic              pinned;
		rsp_t              want;
	} row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req_data = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp_data;
	logic              cfg_we = 1'b0;
	logic [COST_W-1:0] cfg_wdata = '0;

	// Rides along with req_data so the monitor knows which expectation to queue.
	logic row_pinned = 1'b0;
	rsp_t row_expect = '0;

	// Scheduler shadow state.
	logic [TAG_W-1:0]  slot_tag [HEAP_DEPTH];
	logic [ID_W-1:0]   slot_id  [HEAP_DEPTH];
	int                heap_fill = 0;
	logic [TAG_W-1:0]  vclock = '0;
	logic [TAG_W-1:0]  last_finish = '0;
	logic [COST_W-1:0] unit_cost = COST_RESET;

	rsp_t due_responses[$];
	row_t plan[$];

	int   gaps_on = 0;
	int   burst_left = 0;
	int   stall_style = STALL_NONE;
	int   stall_beat = 0;
	int   hold_asks = 0;
	int   hold_taken = 0;
	int   hold_left = 0;

	int   idle_cycles = 0;
	int   mismatches = 0;
	int   requests_taken = 0;
	int   responses_seen = 0;
	int   cost_writes = 0;
	int   deepest = 0;
	int   status_seen [4] = '{0, 0, 0, 0};
	logic progress;
	rsp_t predicted;
	rsp_t want;

	always #5 clk = ~clk;

	tagged_min_heap_request_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Start-time fair queueing step: updates the shadow heap and returns the
	// response this request should produce.
	function automatic rsp_t sfq_step(input req_t item);
		rsp_t             res;
		logic [TAG_W-1:0] start;
		logic [TAG_W:0]   fin_sum;
		logic [TAG_W-1:0] t;
		logic [ID_W-1:0]  d;
		int               pos;
		int               up;
		int               lc;
		int               best;
		logic             moving;
		res = '0;
		res.status = STATUS_OK;
		if (item.operation == OP_ENQUEUE) begin
			// clock catches up with the latest finish only when something is queued
			start = vclock;
			if (heap_fill > 0 && start < last_finish)
				start = last_finish;
			fin_sum = {1'b0, start} + {{(TAG_W + 1 - COST_W){1'b0}}, unit_cost};
			if (heap_fill >= HEAP_DEPTH) begin
				res.status = STATUS_FULL;
			end else if (fin_sum > TAG_LIMIT) begin
				// refused: not even the clock advance sticks
				res.status = STATUS_OVERFLOW;
			end else begin
				vclock = start;
				last_finish = fin_sum[TAG_W-1:0];
				pos = heap_fill;
				moving = 1'b1;
				// sift up past strictly larger parents only
				while (pos > 0 && moving) begin
					up = (pos - 1) / 2;
					if (start < slot_tag[up]) begin
						slot_tag[pos] = slot_tag[up];
						slot_id[pos] = slot_id[up];
						pos = up;
					end else begin
						moving = 1'b0;
					end
				end
				slot_tag[pos] = start;
				slot_id[pos] = item.request_id;
				heap_fill++;
				res.dispatched_tag = start;
			end
		end else if (heap_fill == 0) begin
			res.status = STATUS_EMPTY;
		end else begin
			res.dispatched_id = slot_id[0];
			res.dispatched_tag = slot_tag[0];
			heap_fill--;
			slot_tag[0] = slot_tag[heap_fill];
			slot_id[0] = slot_id[heap_fill];
			pos = 0;
			moving = 1'b1;
			// sift down: left if strictly smaller than node, right if strictly
			// smaller than that pick
			while (moving) begin
				lc = 2 * pos + 1;
				best = pos;
				if (lc < heap_fill && slot_tag[lc] < slot_tag[pos])
					best = lc;
				if (lc + 1 < heap_fill && slot_tag[lc + 1] < slot_tag[best])
					best = lc + 1;
				if (best == pos) begin
					moving = 1'b0;
				end else begin
					t = slot_tag[pos]; slot_tag[pos] = slot_tag[best]; slot_tag[best] = t;
					d = slot_id[pos]; slot_id[pos] = slot_id[best]; slot_id[best] = d;
					pos = best;
				end
			end
		end
		res.queued_count = heap_fill[CNT_W-1:0];
		return res;
	endfunction

	function automatic rsp_t rsp_of(input status_t s, input logic [ID_W-1:0] id,
		input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] cnt);
		rsp_t r;
		r.status = s;
		r.dispatched_id = id;
		r.dispatched_tag = tag;
		r.queued_count = cnt;
		return r;
	endfunction

	function automatic row_t item_row(input op_t op, input logic [ID_W-1:0] id,
		input logic pinned, input rsp_t w);
		row_t r;
		r = '0;
		r.req.operation = op;
		r.req.request_id = id;
		r.pinned = pinned;
		r.want = w;
		return r;
	endfunction

	function automatic row_t cost_row(input logic [COST_W-1:0] c);
		row_t r;
		r = '0;
		r.is_cost = 1'b1;
		r.cost = c;
		return r;
	endfunction

	// Mostly random handles, with the all-zero and all-one extremes mixed in.
	function automatic logic [ID_W-1:0] random_id();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return r[ID_W-1:0];
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer,
	// with valid either still high (caller drives next item now) or lowered for
	// a gap that has already elapsed.
	task automatic offer(input op_t op, input logic [ID_W-1:0] id, input logic pinned,
		input rsp_t w);
		req_t item;
		item.operation = op;
		item.request_id = id;
		req_valid <= 1'b1;
		req_data <= item;
		row_pinned <= pinned;
		row_expect <= w;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		if (gaps_on != 0) begin
			if (burst_left == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(12, 1)) @(negedge clk);
				burst_left = $urandom_range(16, 1);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send(input op_t op, input logic [ID_W-1:0] id);
		offer(op, id, 1'b0, '0);
	endtask

	// Stop offering and wait until every expected response has come back, plus
	// margin for any work still winding down. Returns at a falling edge.
	task automatic drain();
		req_valid <= 1'b0;
		while (due_responses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_cost(input logic [COST_W-1:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		unit_cost = c;
		cost_writes++;
	endtask

	task automatic run_mix(input int count, input int enq_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < enq_pct)
				send(OP_ENQUEUE, random_id());
			else
				send(OP_DISPATCH, random_id());
			// now and then let everything flush before carrying on
			if ($urandom_range(59) == 0)
				drain();
		end
	endtask

	// Receiver: stall pattern chosen per phase, overridden by a long hold-off
	// whenever the stimulus asks for one.
	always @(negedge clk) begin
		stall_beat++;
		if (hold_taken != hold_asks) begin
			hold_taken = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_style)
				STALL_LIGHT: rsp_stall <= ($urandom_range(3) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(9) < 7);
				STALL_BEAT:  rsp_stall <= ((stall_beat % 7) < 3);
				default:     rsp_stall <= 1'b0;
			endcase
		end
	end

	// Monitor: checks responses against the oldest expectation, then queues
	// the expectation for a request taken on this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			progress = 1'b0;
			if (rsp_valid && !rsp_stall) begin
				progress = 1'b1;
				responses_seen++;
				status_seen[rsp_data.status]++;
				if (due_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected response st %0d id %h tag %0d cnt %0d",
							$time, rsp_data.status, rsp_data.dispatched_id,
							rsp_data.dispatched_tag, rsp_data.queued_count);
				end else begin
					want = due_responses.pop_front();
					if (rsp_data.status !== want.status
						|| rsp_data.dispatched_id !== want.dispatched_id
						|| rsp_data.dispatched_tag !== want.dispatched_tag
						|| rsp_data.queued_count !== want.queued_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: exp %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
								$time, want.status, want.dispatched_id, want.dispatched_tag,
								want.queued_count, rsp_data.status, rsp_data.dispatched_id,
								rsp_data.dispatched_tag, rsp_data.queued_count);
					end
				end
			end
			if (req_valid && !req_stall) begin
				progress = 1'b1;
				requests_taken++;
				predicted = sfq_step(req_data);
				due_responses.push_back(row_pinned ? row_expect : predicted);
				if (heap_fill > deepest)
					deepest = heap_fill;
			end
			idle_cycles = progress ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog on transfer activity.
	initial begin
		while (idle_cycles < IDLE_LIMIT) @(posedge clk);
		$display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		// Directed rows. Expectations written out where they are obvious: empty
		// queue, first tags from reset cost 100, FIFO order of rising tags.
		plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b1, rsp_of(STATUS_EMPTY, '0, '0, '0)));
		plan.push_back(item_row(OP_ENQUEUE, 16'h0000, 1'b1, rsp_of(STATUS_OK, '0, 31'd0, 7'd1)));
		plan.push_back(item_row(OP_ENQUEUE, 16'hFFFF, 1'b1, rsp_of(STATUS_OK, '0, 31'd100, 7'd2)));
		plan.push_back(item_row(OP_ENQUEUE, 16'hA5A5, 1'b1, rsp_of(STATUS_OK, '0, 31'd200, 7'd3)));
		plan.push_back(item_row(OP_DISPATCH, 16'h1111, 1'b1,
			rsp_of(STATUS_OK, 16'h0000, 31'd0, 7'd2)));
		plan.push_back(item_row(OP_DISPATCH, 16'h2222, 1'b1,
			rsp_of(STATUS_OK, 16'hFFFF, 31'd100, 7'd1)));
		plan.push_back(item_row(OP_DISPATCH, 16'h3333, 1'b1,
			rsp_of(STATUS_OK, 16'hA5A5, 31'd200, 7'd0)));
		plan.push_back(item_row(OP_DISPATCH, 16'hFFFF, 1'b1, rsp_of(STATUS_EMPTY, '0, '0, '0)));
		// enqueue into an empty queue: clock stays at 200 though latest finish is 300
		plan.push_back(item_row(OP_ENQUEUE, 16'h5A5A, 1'b1, rsp_of(STATUS_OK, '0, 31'd200, 7'd1)));
		plan.push_back(item_row(OP_ENQUEUE, 16'h8001, 1'b1, rsp_of(STATUS_OK, '0, 31'd300, 7'd2)));
		plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b0, '0));
		plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b0, '0));
		// zero cost: every start tag equal, exercises tie handling in both sifts
		plan.push_back(cost_row(16'd0));
		plan.push_back(item_row(OP_ENQUEUE, 16'h0011, 1'b0, '0));
		plan.push_back(item_row(OP_ENQUEUE, 16'h0022, 1'b0, '0));
		plan.push_back(item_row(OP_ENQUEUE, 16'h0033, 1'b0, '0));
		plan.push_back(item_row(OP_ENQUEUE, 16'h0044, 1'b0, '0));
		repeat (4) plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b0, '0));
		// largest cost
		plan.push_back(cost_row(16'hFFFF));
		plan.push_back(item_row(OP_ENQUEUE, 16'h7FFF, 1'b0, '0));
		plan.push_back(item_row(OP_ENQUEUE, 16'h8000, 1'b0, '0));
		plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b0, '0));
		plan.push_back(item_row(OP_DISPATCH, 16'h0000, 1'b0, '0));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gaps_on = 1;
		stall_style = STALL_LIGHT;
		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cost)
				set_cost(plan[i].cost);
			else
				offer(plan[i].req.operation, plan[i].req.request_id, plan[i].pinned,
					plan[i].want);
		end

		// Smallest cost, biased toward enqueues so the heap gets deep.
		set_cost(16'd1);
		run_mix(160, 65);

		// Fill to capacity and past it while the receiver holds off for a long
		// stretch: the block backs up and stalls its request side. Then empty it
		// and dispatch past empty.
		set_cost(16'($urandom_range(65534, 2)));
		hold_asks++;
		repeat (HEAP_DEPTH - heap_fill + 3) send(OP_ENQUEUE, random_id());
		repeat (HEAP_DEPTH + 2) send(OP_DISPATCH, random_id());

		set_cost(16'hFFFF);
		stall_style = STALL_BEAT;
		run_mix(140, 50);

		set_cost(16'd0);
		stall_style = STALL_HEAVY;
		run_mix(100, 55);

		// Back-to-back stretch: no sender gaps, no receiver stalls.
		set_cost(16'($urandom_range(65535, 1)));
		gaps_on = 0;
		stall_style = STALL_NONE;
		run_mix(100, 45);

		// Largest cost with one or two entries kept queued, so every enqueue
		// advances virtual time by the full cost.
		set_cost(16'hFFFF);
		if (heap_fill == 0)
			send(OP_ENQUEUE, random_id());
		repeat (12) begin
			send(OP_ENQUEUE, random_id());
			send(OP_DISPATCH, random_id());
		end
		set_cost(16'd1);
		send(OP_ENQUEUE, random_id());
		gaps_on = 1;
		stall_style = STALL_LIGHT;
		while (heap_fill > 0) send(OP_DISPATCH, random_id());
		send(OP_DISPATCH, random_id());
		send(OP_ENQUEUE, random_id());          // empty queue, clock does not advance

		drain();
		repeat (SETTLE) @(posedge clk);

		$display("run covered %0d requests, %0d responses:", requests_taken, responses_seen);
		$display("ok %0d, empty %0d, full %0d, overflow %0d", status_seen[STATUS_OK],
			status_seen[STATUS_EMPTY], status_seen[STATUS_FULL], status_seen[STATUS_OVERFLOW]);
		$display("%0d cost writes, deepest queue %0d, virtual time reached %0d, %0d mismatches",
			cost_writes, deepest, vclock, mismatches);
		if (due_responses.size() != 0)
			$display("%0d expected responses never arrived", due_responses.size());
		if (mismatches == 0 && due_responses.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
